// File: rtl/dirichlet_query_likelihood_scorer_top_defines.svh
// assertion macros for the query likelihood scorer checker
// used by dqls_checker.sv, needs clk and rst_n in scope
`ifndef DIRICHLET_QUERY_LIKELIHOOD_SCORER_TOP_DEFINES_SVH
`define DIRICHLET_QUERY_LIKELIHOOD_SCORER_TOP_DEFINES_SVH

// same-cycle implication
`define DQLS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dqls assertion failed");

// next-cycle implication
`define DQLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dqls assertion failed");

`endif

// File: rtl/dqls_pkg.sv
// shared constants, types and the ln lookup table for the scorer
// no dependencies
package dqls_pkg;

    localparam int COUNT_BITS     = 24;
    localparam int LOG_TABLE_BITS = 8;
    localparam int TAB_SIZE       = (1 << LOG_TABLE_BITS) + 1;

    localparam int CNT_W  = 24;
    localparam int W_W    = 48;
    localparam int N_W    = W_W + 1;
    localparam int E_W    = 6;
    localparam int REM_W  = 32 - LOG_TABLE_BITS;
    localparam int LN_W   = 39;
    localparam int DIV_STEPS = 65;

    localparam logic [32:0] CNT_MAX = 33'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [W_W-1:0] W_MAX   = {W_W{1'b1}};
    localparam logic [W_W-1:0] W_RESET = 48'd163840000;
    localparam logic [23:0] MU_RESET = 24'd640000;
    localparam logic [23:0] QB_RESET = 24'd65536;
    localparam logic [31:0] LN2_Q32  = 32'd2977044472;

    typedef enum logic [2:0] {
        REG_MU          = 3'd0,
        REG_QUERY_BOOST = 3'd1,
        REG_TERM_TOTAL  = 3'd2,
        REG_FIELD_TOTAL = 3'd3,
        REG_MERGE_MODE  = 3'd4,
        REG_USE_FILTER  = 3'd5
    } reg_idx_t;

    localparam logic [2:0] NUM_REGS = 3'd6;

    localparam logic [1:0] MERGE_OVERWRITE = 2'd0;
    localparam logic [1:0] MERGE_ADD       = 2'd1;
    localparam logic [1:0] MERGE_MAX       = 2'd2;

    typedef struct packed {
        logic [23:0]    mu;
        logic [23:0]    query_boost;
        logic [1:0]     merge_mode;
        logic           use_filter;
        logic [W_W-1:0] weight;
        logic           busy;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] prior;
        logic               blk_end;
        logic [31:0]        boost;
        logic               nzero;
        logic               apply;
    } side_t;

    typedef logic [31:0] ln_tab_t [0:TAB_SIZE-1];

    // restoring shift-subtract quotient, only used while building the table
    function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int j = 63; j >= 0; j--)
        begin
            r = {r[63:0], a[j]};
            if (r >= {1'b0, b})
            begin
                r    = r - {1'b0, b};
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // ln(1 + i/2^LOG_TABLE_BITS) in Q32 via the atanh series, evaluated at elaboration
    function automatic ln_tab_t build_ln_tab();
        ln_tab_t     t;
        logic [63:0] den;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] sum;
        for (int i = 0; i < TAB_SIZE; i++)
        begin
            den  = 64'((1 << (LOG_TABLE_BITS + 1)) + i);
            z    = udiv64(64'(i) << 32, den);
            z2   = (z * z) >> 32;
            term = z;
            sum  = z;
            for (int k = 1; k < 64; k++)
            begin
                if (term != 64'd0)
                begin
                    term = (term * z2) >> 32;
                    sum  = sum + udiv64(term, 64'(2 * k + 1));
                end
            end
            t[i] = 32'(sum << 1);
        end
        return t;
    endfunction

    localparam ln_tab_t LN_TAB = build_ln_tab();

endpackage

// File: rtl/dqls_cfg.sv
// configuration registers and the bit-serial background weight divider
// depends on dqls_pkg
module dqls_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    output dqls_pkg::cfg_t cfg
);
    import dqls_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV} state_t;

    state_t         state_reg;
    logic [23:0]    mu_reg;
    logic [23:0]    qb_reg;
    logic [31:0]    ttf_reg;
    logic [31:0]    ftf_reg;
    logic [1:0]     mode_reg;
    logic           filt_reg;
    logic [W_W-1:0] weight_reg;
    logic [6:0]     cnt_reg;
    logic [64:0]    dvd_reg;
    logic [32:0]    rem_reg;
    logic [W_W-1:0] q_reg;
    logic           ovf_reg;

    logic [32:0]    den;
    logic [33:0]    r2;
    logic           ge;
    logic [32:0]    rem_next;
    logic [W_W-1:0] q_next;
    logic           ovf_next;
    logic [56:0]    prod;

    always_comb
    begin
        den      = {1'b0, ftf_reg} + 33'd1;
        prod     = 57'(mu_reg) * 57'({1'b0, ttf_reg} + 33'd1);
        r2       = {rem_reg, dvd_reg[64]};
        ge       = (r2 >= {1'b0, den});
        rem_next = ge ? 33'(r2 - {1'b0, den}) : r2[32:0];
        q_next   = {q_reg[W_W-2:0], ge};
        // quotient bits above the weight width mean saturation
        ovf_next = ovf_reg | q_reg[W_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mu_reg     <= MU_RESET;
            qb_reg     <= QB_RESET;
            ttf_reg    <= '0;
            ftf_reg    <= '0;
            mode_reg   <= MERGE_OVERWRITE;
            filt_reg   <= 1'b0;
            weight_reg <= W_RESET;
            cnt_reg    <= '0;
            dvd_reg    <= '0;
            rem_reg    <= '0;
            q_reg      <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_MU:          mu_reg   <= cfg_data[23:0];
                REG_QUERY_BOOST: qb_reg   <= cfg_data[23:0];
                REG_TERM_TOTAL:  ttf_reg  <= cfg_data;
                REG_FIELD_TOTAL: ftf_reg  <= cfg_data;
                REG_MERGE_MODE:  mode_reg <= cfg_data[1:0];
                REG_USE_FILTER:  filt_reg <= cfg_data[0];
                default: ;
            endcase
            if (cfg_index < NUM_REGS)
            begin
                state_reg <= ST_MUL;
            end
        end
        else
        begin
            case (state_reg)
                ST_MUL:
                begin
                    dvd_reg   <= {prod, 8'd0};
                    rem_reg   <= '0;
                    q_reg     <= '0;
                    ovf_reg   <= 1'b0;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    dvd_reg <= {dvd_reg[63:0], 1'b0};
                    rem_reg <= rem_next;
                    q_reg   <= q_next;
                    ovf_reg <= ovf_next;
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'(DIV_STEPS - 1))
                    begin
                        weight_reg <= ovf_next ? W_MAX : q_next;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign cfg.mu          = mu_reg;
    assign cfg.query_boost = qb_reg;
    assign cfg.merge_mode  = mode_reg;
    assign cfg.use_filter  = filt_reg;
    assign cfg.weight      = weight_reg;
    assign cfg.busy        = (state_reg != ST_IDLE);

endmodule

// File: rtl/dqls_ln.sv
// four-stage natural log unit: leading one, normalize, table lookup, interpolate
// depends on dqls_pkg (LN_TAB, widths)
module dqls_ln (
    input  logic                      clk,
    input  logic [3:0]                en,
    input  logic [dqls_pkg::N_W-1:0]  x,
    output logic [dqls_pkg::LN_W-1:0] ln
);
    import dqls_pkg::*;

    logic [N_W-1:0]            x1_reg;
    logic [E_W-1:0]            e1_reg;
    logic [E_W-1:0]            e2_reg;
    logic [31:0]               frac2_reg;
    logic [31:0]               lo3_reg;
    logic [31:0]               hi3_reg;
    logic [REM_W-1:0]          rem3_reg;
    logic [37:0]               eln3_reg;
    logic [LN_W-1:0]           ln4_reg;

    logic [E_W-1:0]            lead;
    logic [N_W+31:0]           shifted;
    logic [LOG_TABLE_BITS:0]   idx_lo;
    logic [LOG_TABLE_BITS:0]   idx_hi;
    logic [31:0]               span;
    logic [55:0]               interp;

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < N_W; i++)
        begin
            if (x[i])
            begin
                lead = E_W'(i);
            end
        end
    end

    always_comb
    begin
        shifted = {x1_reg, 32'd0} >> e1_reg;
        idx_lo  = {1'b0, frac2_reg[31:REM_W]};
        idx_hi  = idx_lo + 1'b1;
        span    = hi3_reg - lo3_reg;
        interp  = (56'(span) * 56'(rem3_reg)) >> REM_W;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x1_reg <= x;
            e1_reg <= lead;
        end
        if (en[1])
        begin
            e2_reg    <= e1_reg;
            frac2_reg <= shifted[31:0];
        end
        if (en[2])
        begin
            lo3_reg  <= LN_TAB[idx_lo];
            hi3_reg  <= LN_TAB[idx_hi];
            rem3_reg <= frac2_reg[REM_W-1:0];
            eln3_reg <= 38'(e2_reg) * 38'(LN2_Q32);
        end
        if (en[3])
        begin
            ln4_reg <= LN_W'(eln3_reg) + LN_W'(lo3_reg) + LN_W'(interp);
        end
    end

    assign ln = ln4_reg;

endmodule

// File: rtl/dirichlet_query_likelihood_scorer_top.sv
// Dirichlet-smoothed query likelihood scorer: one posting in, one merged score out. An
// eight-stage pipeline takes one transfer per clock while the output is not stalled and the
// divider is idle; the stages, from input transfer to result valid, are operand prep, four
// log stages, rounding, the boost multiply and the merge/output register. Every write to one
// of the six registers recomputes the background weight mu*P in a bit-serial divider, which
// holds in_ready low through a multiply state and 65 division steps; no item is taken then.
// depends on dqls_pkg, dqls_cfg, dqls_ln
module dirichlet_query_likelihood_scorer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [23:0]        term_frequency,
    input  logic [23:0]        doc_length,
    input  logic [23:0]        item_boost,
    input  logic signed [31:0] prior_score,
    input  logic               block_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] score,
    output logic               scored,
    output logic               block_end_out,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import dqls_pkg::*;

    localparam int STAGES = 8;

    cfg_t cfg;

    logic [STAGES-1:0]  v_reg;
    logic [STAGES:0]    en;
    side_t              side_reg [0:6];

    logic [N_W-1:0]     n0_reg;
    logic [N_W-1:0]     d0_reg;
    logic [LN_W-1:0]    ln_n;
    logic [LN_W-1:0]    ln_d;

    logic               neg5_reg;
    logic [31:0]        lmag5_reg;
    logic               neg6_reg;
    logic [31:0]        prod6_reg;
    logic signed [31:0] score_reg;
    logic               scored_reg;
    logic               be_reg;

    logic [CNT_W-1:0]   tf_c;
    logic [CNT_W-1:0]   dl_c;
    logic [N_W-1:0]     n_next;
    logic [N_W-1:0]     d_next;
    logic [47:0]        boost_prod;
    side_t              side_next;

    logic [LN_W-1:0]    mag;
    logic [LN_W-1:0]    mag_rnd;
    logic               neg_next;
    logic [31:0]        lmag_next;
    logic [63:0]        prod_full;
    logic [31:0]        prod_next;
    logic signed [32:0] s_val;
    logic signed [33:0] sum_val;
    logic signed [31:0] s32;
    logic signed [31:0] sum32;
    logic signed [31:0] score_next;

    dqls_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dqls_ln u_ln_n (
        .clk (clk),
        .en  (en[4:1]),
        .x   (n0_reg),
        .ln  (ln_n)
    );

    dqls_ln u_ln_d (
        .clk (clk),
        .en  (en[4:1]),
        .x   (d0_reg),
        .ln  (ln_d)
    );

    // a stage loads when it is empty or its successor loads
    always_comb
    begin
        en[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0] && !cfg.busy;

    // operand prep
    always_comb
    begin
        tf_c = ({9'd0, term_frequency} > CNT_MAX) ? CNT_MAX[CNT_W-1:0] : term_frequency;
        dl_c = ({9'd0, doc_length} > CNT_MAX) ? CNT_MAX[CNT_W-1:0] : doc_length;
        n_next = N_W'({tf_c, 16'd0}) + N_W'(cfg.weight);
        d_next = N_W'({dl_c, 16'd0}) + N_W'({cfg.mu, 8'd0});
        boost_prod = cfg.query_boost * item_boost;
        side_next.prior   = prior_score;
        side_next.blk_end = block_end;
        side_next.boost   = cfg.use_filter ? boost_prod[47:16] : {8'd0, cfg.query_boost};
        side_next.nzero   = (n_next == '0);
        side_next.apply   = (cfg.mu != 24'd0);
    end

    // log difference rounded to Q16, forced negative with magnitude 2^31 when the numerator is zero
    always_comb
    begin
        neg_next = ln_n < ln_d;
        mag      = neg_next ? (ln_d - ln_n) : (ln_n - ln_d);
        mag_rnd  = (mag + LN_W'(32'h8000)) >> 16;
        lmag_next = 32'(mag_rnd);
        if (side_reg[4].nzero)
        begin
            neg_next  = 1'b1;
            lmag_next = 32'h8000_0000;
        end
    end

    // boost multiply, magnitude clamped to 2^31
    always_comb
    begin
        prod_full = (64'(lmag5_reg) * 64'(side_reg[5].boost) + 64'h8000) >> 16;
        prod_next = (prod_full > 64'h8000_0000) ? 32'h8000_0000 : prod_full[31:0];
    end

    // sign, saturation and merge
    always_comb
    begin
        s_val = neg6_reg ? -$signed({1'b0, prod6_reg}) : $signed({1'b0, prod6_reg});
        s32   = (s_val > 33'sd2147483647) ? 32'sh7FFF_FFFF : s_val[31:0];
        sum_val = 34'(side_reg[6].prior) + 34'(s32);
        if (sum_val > 34'sd2147483647)
        begin
            sum32 = 32'sh7FFF_FFFF;
        end
        else if (sum_val < -34'sd2147483648)
        begin
            sum32 = 32'sh8000_0000;
        end
        else
        begin
            sum32 = sum_val[31:0];
        end
        case (cfg.merge_mode)
            MERGE_ADD: score_next = sum32;
            MERGE_MAX: score_next = (s32 > side_reg[6].prior) ? s32 : side_reg[6].prior;
            default:   score_next = s32;
        endcase
        if (!side_reg[6].apply)
        begin
            score_next = side_reg[6].prior;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid && !cfg.busy;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            n0_reg      <= n_next;
            d0_reg      <= d_next;
            side_reg[0] <= side_next;
        end
        for (int k = 1; k < 7; k++)
        begin
            if (en[k])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
        if (en[5])
        begin
            neg5_reg  <= neg_next;
            lmag5_reg <= lmag_next;
        end
        if (en[6])
        begin
            neg6_reg  <= neg5_reg;
            prod6_reg <= prod_next;
        end
        if (en[7])
        begin
            score_reg  <= score_next;
            scored_reg <= side_reg[6].apply;
            be_reg     <= side_reg[6].blk_end;
        end
    end

    assign out_valid     = v_reg[STAGES-1];
    assign score         = score_reg;
    assign scored        = scored_reg;
    assign block_end_out = be_reg;

endmodule

// File: rtl/dqls_checker.sv
// port-level checker for the scorer, bound to the top level
// depends on dqls_pkg and dirichlet_query_likelihood_scorer_top_defines.svh
`include "dirichlet_query_likelihood_scorer_top_defines.svh"

module dqls_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] score,
    input logic               scored,
    input logic               block_end_out,
    input logic               cfg_we,
    input logic [2:0]         cfg_index
);
    import dqls_pkg::*;

    // a stalled result stays valid and keeps its payload
    `DQLS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `DQLS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable({score, scored, block_end_out}))

    // a register write starts the weight recompute, so input stalls for a while
    `DQLS_ASSERT_NEXT(a_cfg_stall, cfg_we && (cfg_index < NUM_REGS), !in_ready ##1 !in_ready)

    // with the output register empty only the divider can hold off input
    `DQLS_ASSERT_NOW(a_ready_kept, !out_valid && $past(in_ready) && !$past(cfg_we), in_ready)

endmodule

bind dirichlet_query_likelihood_scorer_top dqls_checker u_dqls_checker (.*);
